[sv/ihex_pkg.sv]
// package: shared types, constants and a helper of the hex image loader
package ihex_pkg;

    localparam int ADDR_BITS_DEF        = 24;
    localparam int MAX_RECORD_BYTES_DEF = 32;
    localparam int LINE_COUNT_BITS_DEF  = 20;

    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_COLON = 8'h3A;

    localparam logic [8:0] TOKEN_CAP   = 9'd511;
    localparam logic [8:0] TOKEN_MIN   = 9'd11;
    localparam logic [7:0] RESULT_LIM  = 8'd32;
    localparam logic [19:0] SEG_LIMIT  = 20'h10000;

    typedef enum logic [1:0] {
        KIND_WRITE   = 2'd0,
        KIND_ERROR   = 2'd1,
        KIND_SUMMARY = 2'd2
    } result_kind_t;

    typedef enum logic [3:0] {
        ERR_NONE      = 4'd0,
        ERR_SHORT     = 4'd1,
        ERR_MISSING   = 4'd2,
        ERR_TOO_LONG  = 4'd3,
        ERR_CHECKSUM  = 4'd4,
        ERR_EOF_REC   = 4'd5,
        ERR_SEG_FORM  = 4'd6,
        ERR_SEG_VALUE = 4'd7,
        ERR_LIN_FORM  = 4'd8,
        ERR_LIN_VALUE = 4'd9,
        ERR_BAD_TYPE  = 4'd10,
        ERR_NO_DATA   = 4'd11,
        ERR_OVERFLOW  = 4'd12
    } err_code_t;

    typedef enum logic [7:0] {
        REC_DATA   = 8'h00,
        REC_EOF    = 8'h01,
        REC_SEG    = 8'h02,
        REC_LINEAR = 8'h04
    } rec_type_t;

    typedef enum logic [2:0] {
        PH_FRESH,
        PH_BLANKS,
        PH_TOKEN,
        PH_TAIL,
        PH_SKIP,
        PH_HALT
    } phase_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_RD,
        BK_PUT,
        BK_ERR,
        BK_SUM
    } back_state_t;

    // control part of one command from the parser to the emitter
    typedef struct packed {
        logic       do_writes;
        logic [7:0] count;
        logic       do_err;
        err_code_t  err_code;
        logic       do_sum;
        err_code_t  sum_code;
    } cmd_ctrl_t;

    // record byte store write
    typedef struct packed {
        logic       we;
        logic [7:0] idx;
        logic [7:0] data;
    } rec_wr_t;

    function automatic logic [3:0] hex_value(input logic [7:0] c);
        logic [3:0] v;
        v = 4'd0;
        if (c >= 8'h30 && c <= 8'h39) v = 4'(c - 8'h30);
        else if (c >= 8'h41 && c <= 8'h46) v = 4'(c - 8'h37);
        else if (c >= 8'h61 && c <= 8'h66) v = 4'(c - 8'h57);
        return v;
    endfunction

endpackage

[sv/ihex_cmd_queue.sv]
// two-entry command queue between parser and emitter
module ihex_cmd_queue #(
    parameter int WIDTH = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    input  logic             pop,
    output logic [WIDTH-1:0] head,
    output logic             empty,
    output logic             full
);
    logic [WIDTH-1:0] slot_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] cnt_reg, cnt_next;

    assign empty = (cnt_reg == 2'd0);
    assign full  = (cnt_reg == 2'd2);
    assign head  = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push && !full)
        begin
            wr_ptr_next = ~wr_ptr_reg;
        end
        if (pop && !empty)
        begin
            rd_ptr_next = ~rd_ptr_reg;
        end
        cnt_next = cnt_reg + 2'((push && !full) ? 1 : 0) - 2'((pop && !empty) ? 1 : 0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push && !full)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end
endmodule

[sv/ihex_front.sv]
// record parser: character handling, record checks, address bookkeeping
module ihex_front #(
    parameter int ADDR_BITS        = ihex_pkg::ADDR_BITS_DEF,
    parameter int MAX_RECORD_BYTES = ihex_pkg::MAX_RECORD_BYTES_DEF,
    parameter int LINE_COUNT_BITS  = ihex_pkg::LINE_COUNT_BITS_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [7:0]                 char_code,
    input  logic                       end_of_stream,
    input  logic                       queue_empty,
    input  logic                       back_idle,
    output logic                       push,
    output ihex_pkg::cmd_ctrl_t        cmd_ctrl,
    output logic [ADDR_BITS:0]         cmd_base,
    output logic [LINE_COUNT_BITS-1:0] cmd_line,
    output logic [ADDR_BITS:0]         cmd_low,
    output logic [ADDR_BITS:0]         cmd_high,
    output ihex_pkg::rec_wr_t          rec_wr
);
    import ihex_pkg::*;

    localparam logic [ADDR_BITS:0] MEM_SIZE = (ADDR_BITS+1)'(1) << ADDR_BITS;
    localparam logic [32:0] LIN_TOP = (33'(1) << ADDR_BITS) - 33'h10000;
    localparam logic [7:0] MAX_BYTES = 8'(MAX_RECORD_BYTES);

    phase_t                     phase_reg, phase_next;
    logic [8:0]                 tcc_reg, tcc_next;
    logic [3:0]                 nib_reg, nib_next;
    logic [7:0]                 cnt_reg, cnt_next;
    logic [15:0]                raddr_reg, raddr_next;
    logic [7:0]                 rtype_reg, rtype_next;
    logic [7:0]                 sum_reg, sum_next;
    logic [7:0]                 chk_reg, chk_next;
    logic [7:0]                 d0_reg, d0_next;
    logic [7:0]                 d1_reg, d1_next;
    logic [ADDR_BITS-1:0]       offset_reg, offset_next;
    logic [ADDR_BITS:0]         low_reg, low_next;
    logic [ADDR_BITS:0]         high_reg, high_next;
    logic [LINE_COUNT_BITS-1:0] line_reg, line_next;
    err_code_t                  sticky_reg, sticky_next;

    logic       accept, blank, fin, bump;
    logic [3:0] hv;
    logic [7:0] b, idx, ri, limit;
    err_code_t  code, sticky_post, sum_code;
    logic [ADDR_BITS:0] base, top, low_post, high_post;
    logic [19:0] seg_v;
    logic [32:0] lin_v;
    logic [LINE_COUNT_BITS-1:0] line_after;
    logic [ADDR_BITS-1:0] offset_post;

    assign in_ready = queue_empty && back_idle;
    assign accept   = in_valid && in_ready;
    assign blank    = (char_code == CH_SPACE) || (char_code == CH_TAB);
    assign hv       = hex_value(char_code);

    // record verdict, from the state held before this character
    always_comb
    begin
        limit = end_of_stream ? RESULT_LIM - 8'd1 : RESULT_LIM;
        base  = {1'b0, offset_reg} + (ADDR_BITS+1)'(raddr_reg);
        top   = base + (ADDR_BITS+1)'(cnt_reg) - (ADDR_BITS+1)'(1);
        seg_v = {d0_reg, d1_reg, 4'h0};
        lin_v = 33'({d0_reg, d1_reg, 16'h0000});
        code        = ERR_NONE;
        offset_post = offset_reg;
        low_post    = low_reg;
        high_post   = high_reg;
        if (tcc_reg < TOKEN_MIN)
            code = ERR_SHORT;
        else if (cnt_reg > MAX_BYTES || cnt_reg > limit)
            code = ERR_TOO_LONG;
        else if ({1'b0, tcc_reg} < 10'd11 + {1'b0, cnt_reg, 1'b0})
            code = ERR_MISSING;
        else if (8'(-sum_reg) != chk_reg)
            code = ERR_CHECKSUM;
        else
        begin
            case (rtype_reg)
                REC_DATA:
                begin
                    if (cnt_reg != 8'd0)
                    begin
                        if (top > high_reg) high_post = top;
                        if (base < low_reg) low_post = base;
                    end
                end
                REC_EOF:
                begin
                    if (cnt_reg != 8'd0 || raddr_reg != 16'd0) code = ERR_EOF_REC;
                end
                REC_SEG:
                begin
                    if (cnt_reg != 8'd2 || raddr_reg != 16'd0) code = ERR_SEG_FORM;
                    else if (seg_v > SEG_LIMIT) code = ERR_SEG_VALUE;
                    else offset_post = ADDR_BITS'(seg_v);
                end
                REC_LINEAR:
                begin
                    if (cnt_reg != 8'd2 || raddr_reg != 16'd0) code = ERR_LIN_FORM;
                    else if (lin_v > LIN_TOP) code = ERR_LIN_VALUE;
                    else offset_post = ADDR_BITS'(lin_v);
                end
                default: code = ERR_BAD_TYPE;
            endcase
        end
    end

    always_comb
    begin
        phase_next  = phase_reg;
        tcc_next    = tcc_reg;
        nib_next    = nib_reg;
        cnt_next    = cnt_reg;
        raddr_next  = raddr_reg;
        rtype_next  = rtype_reg;
        sum_next    = sum_reg;
        chk_next    = chk_reg;
        d0_next     = d0_reg;
        d1_next     = d1_reg;
        offset_next = offset_reg;
        low_next    = low_reg;
        high_next   = high_reg;
        sticky_next = sticky_reg;
        rec_wr      = '0;
        fin         = 1'b0;
        bump        = 1'b0;
        b           = {nib_reg, hv};
        idx         = 8'(tcc_reg[8:1]) - 8'd1;
        ri          = idx - 8'd4;

        if (accept)
        begin
            if (end_of_stream)
            begin
                fin  = (phase_reg == PH_TOKEN) || (phase_reg == PH_TAIL);
                bump = fin || (phase_reg == PH_BLANKS) || (phase_reg == PH_SKIP);
            end
            else
            begin
                case (phase_reg)
                    PH_FRESH, PH_BLANKS:
                    begin
                        if (char_code == CH_NL)
                        begin
                            bump = 1'b1;
                            phase_next = PH_FRESH;
                        end
                        else if (blank)
                            phase_next = PH_BLANKS;
                        else if (char_code == CH_COLON)
                        begin
                            phase_next = PH_TOKEN;
                            tcc_next   = 9'd1;
                            nib_next   = 4'd0;
                            cnt_next   = 8'd0;
                            raddr_next = 16'd0;
                            rtype_next = 8'd0;
                            sum_next   = 8'd0;
                            chk_next   = 8'd0;
                        end
                        else
                            phase_next = PH_SKIP;
                    end
                    PH_SKIP:
                    begin
                        if (char_code == CH_NL)
                        begin
                            bump = 1'b1;
                            phase_next = PH_FRESH;
                        end
                    end
                    PH_TAIL:
                    begin
                        if (char_code == CH_NL)
                        begin
                            bump = 1'b1;
                            fin  = 1'b1;
                        end
                    end
                    PH_TOKEN:
                    begin
                        if (char_code == CH_NL)
                        begin
                            bump = 1'b1;
                            fin  = 1'b1;
                        end
                        else if (blank)
                            phase_next = PH_TAIL;
                        else if (tcc_reg < TOKEN_CAP)
                        begin
                            tcc_next = tcc_reg + 9'd1;
                            if (tcc_reg[0])
                                nib_next = hv;
                            else
                            begin
                                case (idx)
                                    8'd0: begin cnt_next = b; sum_next = sum_reg + b; end
                                    8'd1: begin raddr_next = {b, 8'h00}; sum_next = sum_reg + b; end
                                    8'd2: begin raddr_next = raddr_reg | 16'(b); sum_next = sum_reg + b; end
                                    8'd3: begin rtype_next = b; sum_next = sum_reg + b; end
                                    default:
                                    begin
                                        if (ri < cnt_reg)
                                        begin
                                            sum_next = sum_reg + b;
                                            if (ri < MAX_BYTES)
                                            begin
                                                rec_wr.we   = 1'b1;
                                                rec_wr.idx  = ri;
                                                rec_wr.data = b;
                                            end
                                            if (ri == 8'd0) d0_next = b;
                                            if (ri == 8'd1) d1_next = b;
                                        end
                                        else if (ri == cnt_reg)
                                            chk_next = b;
                                    end
                                endcase
                            end
                        end
                    end
                    default: ;
                endcase
            end
        end

        line_after = (bump && line_reg != '1) ? line_reg + LINE_COUNT_BITS'(1) : line_reg;
        line_next  = line_after;

        sticky_post = sticky_reg;
        if (fin)
        begin
            if (code != ERR_NONE)
            begin
                sticky_post = code;
                phase_next  = PH_HALT;
            end
            else
            begin
                phase_next  = PH_FRESH;
                offset_next = offset_post;
                low_next    = low_post;
                high_next   = high_post;
            end
        end
        sticky_next = sticky_post;

        if (sticky_post != ERR_NONE) sum_code = sticky_post;
        else if (low_next >= MEM_SIZE) sum_code = ERR_NO_DATA;
        else if (high_next >= MEM_SIZE) sum_code = ERR_OVERFLOW;
        else sum_code = ERR_NONE;

        push               = fin || (accept && end_of_stream);
        cmd_ctrl.do_writes = fin && (code == ERR_NONE) && (rtype_reg == REC_DATA)
                             && (cnt_reg != 8'd0);
        cmd_ctrl.count     = cnt_reg;
        cmd_ctrl.do_err    = fin && (code != ERR_NONE);
        cmd_ctrl.err_code  = code;
        cmd_ctrl.do_sum    = accept && end_of_stream;
        cmd_ctrl.sum_code  = sum_code;
        cmd_base = base;
        cmd_line = line_after;
        cmd_low  = low_next;
        cmd_high = high_next;

        // end of stream restarts the parser
        if (accept && end_of_stream)
        begin
            phase_next  = PH_FRESH;
            tcc_next    = 9'd0;
            nib_next    = 4'd0;
            cnt_next    = 8'd0;
            raddr_next  = 16'd0;
            rtype_next  = 8'd0;
            sum_next    = 8'd0;
            chk_next    = 8'd0;
            offset_next = '0;
            low_next    = MEM_SIZE;
            high_next   = '0;
            line_next   = '0;
            sticky_next = ERR_NONE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_FRESH;
            tcc_reg    <= 9'd0;
            nib_reg    <= 4'd0;
            cnt_reg    <= 8'd0;
            raddr_reg  <= 16'd0;
            rtype_reg  <= 8'd0;
            sum_reg    <= 8'd0;
            chk_reg    <= 8'd0;
            d0_reg     <= 8'd0;
            d1_reg     <= 8'd0;
            offset_reg <= '0;
            low_reg    <= MEM_SIZE;
            high_reg   <= '0;
            line_reg   <= '0;
            sticky_reg <= ERR_NONE;
        end
        else
        begin
            phase_reg  <= phase_next;
            tcc_reg    <= tcc_next;
            nib_reg    <= nib_next;
            cnt_reg    <= cnt_next;
            raddr_reg  <= raddr_next;
            rtype_reg  <= rtype_next;
            sum_reg    <= sum_next;
            chk_reg    <= chk_next;
            d0_reg     <= d0_next;
            d1_reg     <= d1_next;
            offset_reg <= offset_next;
            low_reg    <= low_next;
            high_reg   <= high_next;
            line_reg   <= line_next;
            sticky_reg <= sticky_next;
        end
    end
endmodule

[sv/ihex_back.sv]
// result emitter: byte writes from the record store, error and summary results
module ihex_back #(
    parameter int ADDR_BITS        = ihex_pkg::ADDR_BITS_DEF,
    parameter int MAX_RECORD_BYTES = ihex_pkg::MAX_RECORD_BYTES_DEF,
    parameter int LINE_COUNT_BITS  = ihex_pkg::LINE_COUNT_BITS_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  ihex_pkg::rec_wr_t          rec_wr,
    input  logic                       queue_empty,
    output logic                       pop,
    output logic                       idle,
    input  ihex_pkg::cmd_ctrl_t        cmd_ctrl,
    input  logic [ADDR_BITS:0]         cmd_base,
    input  logic [LINE_COUNT_BITS-1:0] cmd_line,
    input  logic [ADDR_BITS:0]         cmd_low,
    input  logic [ADDR_BITS:0]         cmd_high,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [1:0]                 result_kind,
    output logic [ADDR_BITS-1:0]       write_address,
    output logic [7:0]                 write_data,
    output logic [3:0]                 error_code,
    output logic [LINE_COUNT_BITS-1:0] line_number,
    output logic [ADDR_BITS:0]         lowest_address,
    output logic [ADDR_BITS:0]         highest_address,
    output logic                       last_of_run
);
    import ihex_pkg::*;

    localparam int IDX_BITS = $clog2(MAX_RECORD_BYTES);

    logic [7:0] store [MAX_RECORD_BYTES];
    logic [7:0] rd_data_reg;

    back_state_t state_reg, state_next;
    cmd_ctrl_t   ctrl_reg, ctrl_next;
    logic [ADDR_BITS:0]         base_reg, base_next;
    logic [LINE_COUNT_BITS-1:0] line_reg, line_next;
    logic [ADDR_BITS:0]         low_reg, low_next;
    logic [ADDR_BITS:0]         high_reg, high_next;
    logic [7:0]                 i_reg, i_next;

    logic                       ovalid_reg, ovalid_next;
    result_kind_t               okind_reg, okind_next;
    logic [ADDR_BITS-1:0]       oaddr_reg, oaddr_next;
    logic [7:0]                 odata_reg, odata_next;
    err_code_t                  oerr_reg, oerr_next;
    logic [LINE_COUNT_BITS-1:0] oline_reg, oline_next;
    logic [ADDR_BITS:0]         olow_reg, olow_next;
    logic [ADDR_BITS:0]         ohigh_reg, ohigh_next;
    logic                       olast_reg, olast_next;

    logic slot_free, in_range, next_in_range;
    logic [ADDR_BITS:0] wa, wa_n;
    back_state_t after_writes;

    always_ff @(posedge clk)
    begin
        if (rec_wr.we)
        begin
            store[rec_wr.idx[IDX_BITS-1:0]] <= rec_wr.data;
        end
        rd_data_reg <= store[i_reg[IDX_BITS-1:0]];
    end

    assign idle          = (state_reg == BK_IDLE);
    assign slot_free     = !ovalid_reg || out_ready;
    assign wa            = base_reg + (ADDR_BITS+1)'(i_reg);
    assign wa_n          = wa + (ADDR_BITS+1)'(1);
    assign in_range      = !wa[ADDR_BITS];
    assign next_in_range = !wa_n[ADDR_BITS];

    always_comb
    begin
        state_next  = state_reg;
        ctrl_next   = ctrl_reg;
        base_next   = base_reg;
        line_next   = line_reg;
        low_next    = low_reg;
        high_next   = high_reg;
        i_next      = i_reg;
        pop         = 1'b0;
        ovalid_next = ovalid_reg && !out_ready;
        okind_next  = okind_reg;
        oaddr_next  = oaddr_reg;
        odata_next  = odata_reg;
        oerr_next   = oerr_reg;
        oline_next  = oline_reg;
        olow_next   = olow_reg;
        ohigh_next  = ohigh_reg;
        olast_next  = olast_reg;

        if (ctrl_reg.do_err) after_writes = BK_ERR;
        else if (ctrl_reg.do_sum) after_writes = BK_SUM;
        else after_writes = BK_IDLE;

        case (state_reg)
            BK_IDLE:
            begin
                if (!queue_empty)
                begin
                    pop       = 1'b1;
                    ctrl_next = cmd_ctrl;
                    base_next = cmd_base;
                    line_next = cmd_line;
                    low_next  = cmd_low;
                    high_next = cmd_high;
                    i_next    = 8'd0;
                    if (cmd_ctrl.do_writes) state_next = BK_RD;
                    else if (cmd_ctrl.do_err) state_next = BK_ERR;
                    else if (cmd_ctrl.do_sum) state_next = BK_SUM;
                end
            end
            BK_RD:
            begin
                // addresses rise, so the first one past the memory ends the run
                if (i_reg == ctrl_reg.count || !in_range) state_next = after_writes;
                else state_next = BK_PUT;
            end
            BK_PUT:
            begin
                if (slot_free)
                begin
                    ovalid_next = 1'b1;
                    okind_next  = KIND_WRITE;
                    oaddr_next  = wa[ADDR_BITS-1:0];
                    odata_next  = rd_data_reg;
                    oerr_next   = ERR_NONE;
                    oline_next  = line_reg;
                    olow_next   = low_reg;
                    ohigh_next  = high_reg;
                    olast_next  = (i_reg == ctrl_reg.count - 8'd1 || !next_in_range)
                                  && !ctrl_reg.do_sum;
                    i_next      = i_reg + 8'd1;
                    state_next  = BK_RD;
                end
            end
            BK_ERR:
            begin
                if (slot_free)
                begin
                    ovalid_next = 1'b1;
                    okind_next  = KIND_ERROR;
                    oaddr_next  = '0;
                    odata_next  = 8'd0;
                    oerr_next   = ctrl_reg.err_code;
                    oline_next  = line_reg;
                    olow_next   = low_reg;
                    ohigh_next  = high_reg;
                    olast_next  = !ctrl_reg.do_sum;
                    state_next  = ctrl_reg.do_sum ? BK_SUM : BK_IDLE;
                end
            end
            BK_SUM:
            begin
                if (slot_free)
                begin
                    ovalid_next = 1'b1;
                    okind_next  = KIND_SUMMARY;
                    oaddr_next  = '0;
                    odata_next  = 8'd0;
                    oerr_next   = ctrl_reg.sum_code;
                    oline_next  = line_reg;
                    olow_next   = low_reg;
                    ohigh_next  = high_reg;
                    olast_next  = 1'b1;
                    state_next  = BK_IDLE;
                end
            end
            default: state_next = BK_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= BK_IDLE;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ctrl_reg  <= ctrl_next;
        base_reg  <= base_next;
        line_reg  <= line_next;
        low_reg   <= low_next;
        high_reg  <= high_next;
        i_reg     <= i_next;
        okind_reg <= okind_next;
        oaddr_reg <= oaddr_next;
        odata_reg <= odata_next;
        oerr_reg  <= oerr_next;
        oline_reg <= oline_next;
        olow_reg  <= olow_next;
        ohigh_reg <= ohigh_next;
        olast_reg <= olast_next;
    end

    assign out_valid       = ovalid_reg;
    assign result_kind     = okind_reg;
    assign write_address   = oaddr_reg;
    assign write_data      = odata_reg;
    assign error_code      = oerr_reg;
    assign line_number     = oline_reg;
    assign lowest_address  = olow_reg;
    assign highest_address = ohigh_reg;
    assign last_of_run     = olast_reg;

`ifndef SYNTHESIS
    a_put_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == BK_PUT) |-> (in_range && i_reg < ctrl_reg.count))
        else $error("byte write outside record or memory");
    a_summary_last: assert property (@(posedge clk) disable iff (!rst_n)
        (ovalid_reg && okind_reg == KIND_SUMMARY) |-> olast_reg)
        else $error("summary not marked last");
    a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> (state_reg != BK_IDLE || !ctrl_reg.do_writes))
        else $error("command popped but no work started");
`endif
endmodule

[sv/intel_hex_image_loader_top.sv]
// top level of the hex image loader
// Takes a hex file one character per request on the slave side and gives byte
// writes, error reports and an end-of-stream summary on the master side. Each
// character goes to the parser; a line end that closes a data record then
// hands a command through a two-entry queue to the emitter, which reads each
// byte to write from the store and then loads it into the output register,
// waiting while that register still holds a result not yet taken. The parser
// takes no new character until the emitter has finished its command and the
// queue is empty. The output register lets the next character be taken while
// the last result still waits on the master side.
module intel_hex_image_loader_top #(
    parameter int ADDR_BITS        = ihex_pkg::ADDR_BITS_DEF,
    parameter int MAX_RECORD_BYTES = ihex_pkg::MAX_RECORD_BYTES_DEF,
    parameter int LINE_COUNT_BITS  = ihex_pkg::LINE_COUNT_BITS_DEF,
    localparam int DATA_BITS = ADDR_BITS + 8 + 4 + LINE_COUNT_BITS + 2 * (ADDR_BITS + 1),
    localparam int TDATA_BITS = ((DATA_BITS + 7) / 8) * 8
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [7:0]            s_tdata,   // char_code
    input  logic                  s_tlast,   // end_of_stream
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // write_address, write_data, error_code, line_number, lowest_address,
    // highest_address
    output logic [TDATA_BITS-1:0] m_tdata,
    output logic [1:0]            m_tuser,   // result_kind
    output logic                  m_tlast    // last_of_run
);
    import ihex_pkg::*;

    localparam int CMD_BITS = $bits(cmd_ctrl_t) + 3 * (ADDR_BITS + 1) + LINE_COUNT_BITS;

    // parser side
    logic                       push, q_empty, q_full, pop, back_idle;
    cmd_ctrl_t                  f_ctrl, b_ctrl;
    logic [ADDR_BITS:0]         f_base, f_low, f_high, b_base, b_low, b_high;
    logic [LINE_COUNT_BITS-1:0] f_line, b_line;
    rec_wr_t                    rec_wr;
    logic [CMD_BITS-1:0]        q_head;

    // emitter side
    logic [ADDR_BITS-1:0]       write_address;
    logic [7:0]                 write_data;
    logic [3:0]                 error_code;
    logic [LINE_COUNT_BITS-1:0] line_number;
    logic [ADDR_BITS:0]         lowest_address, highest_address;

    ihex_front #(
        .ADDR_BITS        (ADDR_BITS),
        .MAX_RECORD_BYTES (MAX_RECORD_BYTES),
        .LINE_COUNT_BITS  (LINE_COUNT_BITS)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (s_tvalid),
        .in_ready      (s_tready),
        .char_code     (s_tdata),
        .end_of_stream (s_tlast),
        .queue_empty   (q_empty),
        .back_idle     (back_idle),
        .push          (push),
        .cmd_ctrl      (f_ctrl),
        .cmd_base      (f_base),
        .cmd_line      (f_line),
        .cmd_low       (f_low),
        .cmd_high      (f_high),
        .rec_wr        (rec_wr)
    );

    // commands cross to the emitter through a short queue
    ihex_cmd_queue #(
        .WIDTH (CMD_BITS)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data ({f_ctrl, f_base, f_line, f_low, f_high}),
        .pop       (pop),
        .head      (q_head),
        .empty     (q_empty),
        .full      (q_full)
    );

    assign {b_ctrl, b_base, b_line, b_low, b_high} = q_head;

    ihex_back #(
        .ADDR_BITS        (ADDR_BITS),
        .MAX_RECORD_BYTES (MAX_RECORD_BYTES),
        .LINE_COUNT_BITS  (LINE_COUNT_BITS)
    ) u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .rec_wr          (rec_wr),
        .queue_empty     (q_empty),
        .pop             (pop),
        .idle            (back_idle),
        .cmd_ctrl        (b_ctrl),
        .cmd_base        (b_base),
        .cmd_line        (b_line),
        .cmd_low         (b_low),
        .cmd_high        (b_high),
        .out_valid       (m_tvalid),
        .out_ready       (m_tready),
        .result_kind     (m_tuser),
        .write_address   (write_address),
        .write_data      (write_data),
        .error_code      (error_code),
        .line_number     (line_number),
        .lowest_address  (lowest_address),
        .highest_address (highest_address),
        .last_of_run     (m_tlast)
    );

    // fields packed from the lowest bit up, zero filled to whole bytes
    assign m_tdata = TDATA_BITS'({highest_address, lowest_address, line_number,
                                  error_code, write_data, write_address});

`ifndef SYNTHESIS
    a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !q_full)
        else $error("command pushed into a full queue");
    a_ready_needs_idle: assert property (@(posedge clk) disable iff (!rst_n)
        s_tready |-> (back_idle && q_empty))
        else $error("character taken while emitter busy");
    a_store_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
        rec_wr.we |-> back_idle)
        else $error("record store written during emission");
`endif
endmodule

[test/intel_hex_image_loader_top_tb.sv]
// testbench for the hex image loader top level
`timescale 1ns / 1ps

module intel_hex_image_loader_top_tb;
    import ihex_pkg::*;

    localparam int ABITS  = 24;
    localparam int RECMAX = 32;
    localparam int LBITS  = 20;
    localparam int TDW    = 112;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int ITEM_TARGET = 300;
    localparam logic [24:0] MEM_TOP = 25'h1000000;

    // one result as seen on the master side
    typedef struct packed {
        result_kind_t kind;
        logic [23:0]  addr;
        logic [7:0]   data;
        err_code_t    code;
        logic [19:0]  line;
        logic [24:0]  low;
        logic [24:0]  high;
        logic         last;
    } loader_result_t;

    logic                 clk;
    logic                 rst_n;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [7:0]           s_tdata;
    logic                 s_tlast;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [TDW-1:0]       m_tdata;
    logic [1:0]           m_tuser;
    logic                 m_tlast;

    intel_hex_image_loader_top dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    initial clk = 1'b0;
    always #2 clk = ~clk;

    // parser state mirrored by the predictor
    phase_t       pr_phase;
    int unsigned  pr_tok;
    logic [3:0]   pr_nib;
    logic [7:0]   pr_count;
    logic [15:0]  pr_addr;
    logic [7:0]   pr_type;
    logic [7:0]   pr_sum;
    logic [7:0]   pr_check;
    logic [7:0]   pr_bytes [RECMAX];
    logic [24:0]  pr_offset;
    logic [24:0]  pr_low;
    logic [24:0]  pr_high;
    logic [19:0]  pr_lines;
    err_code_t    pr_sticky;

    loader_result_t pending_q [$];
    int           last_code;       // code of the latest predicted result
    int           mismatches;
    int           chars_sent;
    int           writes_seen;
    int           errors_seen;
    int           summaries_seen;
    int           idle_cycles;
    bit           tx_calm;         // no gaps on the sender side
    bit           rx_calm;
    int           rx_hold;

    function automatic logic [3:0] nibble_of(input logic [7:0] c);
        if (c >= "0" && c <= "9") return c[3:0];
        if ((c >= "A" && c <= "F") || (c >= "a" && c <= "f")) return c[3:0] + 4'd9;
        return 4'd0;
    endfunction

    task automatic clear_parser();
        pr_phase  = PH_FRESH;
        pr_tok    = 0;
        pr_nib    = '0;
        pr_count  = '0;
        pr_addr   = '0;
        pr_type   = '0;
        pr_sum    = '0;
        pr_check  = '0;
        pr_offset = '0;
        pr_low    = MEM_TOP;
        pr_high   = '0;
        pr_lines  = '0;
        pr_sticky = ERR_NONE;
    endtask

    task automatic queue_result(input result_kind_t k, input logic [23:0] a,
                                input logic [7:0] d, input err_code_t e);
        loader_result_t r;
        r.kind = k;
        r.addr = a;
        r.data = d;
        r.code = e;
        r.line = pr_lines;
        r.low  = pr_low;
        r.high = pr_high;
        r.last = 1'b0;
        pending_q.push_back(r);
        last_code = e;
    endtask

    task automatic count_line();
        if (pr_lines != '1) pr_lines = pr_lines + 1'b1;
    endtask

    task automatic absorb_char(input logic [7:0] c);
        int unsigned p;
        int unsigned idx;
        logic [7:0]  b;
        p = pr_tok;
        if (p >= 511) return;
        pr_tok = p + 1;
        if (p % 2 == 1)
        begin
            pr_nib = nibble_of(c);
            return;
        end
        b = {pr_nib, nibble_of(c)};
        idx = p / 2 - 1;
        case (idx)
            0: pr_count = b;
            1: pr_addr[15:8] = b;
            2: pr_addr[7:0] = b;
            3: pr_type = b;
            default:
            begin
                if (idx - 4 < pr_count)
                begin
                    if (idx - 4 < RECMAX) pr_bytes[idx - 4] = b;
                end
                else
                begin
                    if (idx - 4 == pr_count) pr_check = b;
                    return;
                end
            end
        endcase
        pr_sum = pr_sum + b;
    endtask

    // line end: length and checksum checks, then the record's action
    task automatic close_record(input bit at_end);
        err_code_t   e;
        int unsigned n;
        longint      base;
        longint      seg;
        n = pr_count;
        e = ERR_NONE;
        if (pr_tok < 11) e = ERR_SHORT;
        else if (n > RECMAX || n > (at_end ? 31 : 32)) e = ERR_TOO_LONG;
        else if (pr_tok < 11 + 2 * n) e = ERR_MISSING;
        else if (8'(-pr_sum) != pr_check) e = ERR_CHECKSUM;
        else if (pr_type == REC_DATA)
        begin
            if (n > 0)
            begin
                base = longint'(pr_offset) + pr_addr;
                if (base + n - 1 > pr_high) pr_high = 25'(base + n - 1);
                if (base < pr_low) pr_low = 25'(base);
                for (int i = 0; i < n; i++)
                    if (base + i < MEM_TOP) queue_result(KIND_WRITE, 24'(base + i),
                                                         pr_bytes[i], ERR_NONE);
            end
        end
        else if (pr_type == REC_EOF)
        begin
            if (n != 0 || pr_addr != 0) e = ERR_EOF_REC;
        end
        else if (pr_type == REC_SEG)
        begin
            if (n != 2 || pr_addr != 0) e = ERR_SEG_FORM;
            else
            begin
                seg = {pr_bytes[0], pr_bytes[1]} * 16;
                if (seg > 'h10000) e = ERR_SEG_VALUE;
                else pr_offset = 25'(seg);
            end
        end
        else if (pr_type == REC_LINEAR)
        begin
            if (n != 2 || pr_addr != 0) e = ERR_LIN_FORM;
            else
            begin
                seg = longint'({pr_bytes[0], pr_bytes[1]}) << 16;
                if (seg > MEM_TOP - 'h10000) e = ERR_LIN_VALUE;
                else pr_offset = 25'(seg);
            end
        end
        else e = ERR_BAD_TYPE;
        if (e != ERR_NONE)
        begin
            pr_sticky = e;
            pr_phase  = PH_HALT;
            queue_result(KIND_ERROR, '0, '0, e);
        end
        else pr_phase = PH_FRESH;
    endtask

    // works out the results of one accepted request
    task automatic predict_request(input logic [7:0] c, input bit eos);
        int        depth_at_entry;
        err_code_t e;
        bit        blank;
        depth_at_entry = pending_q.size();
        blank = (c == CH_SPACE || c == CH_TAB);
        if (eos)
        begin
            if (pr_phase == PH_TOKEN || pr_phase == PH_TAIL)
            begin
                count_line();
                close_record(1'b1);
            end
            else if (pr_phase == PH_BLANKS || pr_phase == PH_SKIP) count_line();
            if (pr_sticky != ERR_NONE) e = pr_sticky;
            else if (pr_low >= MEM_TOP) e = ERR_NO_DATA;
            else if (pr_high >= MEM_TOP) e = ERR_OVERFLOW;
            else e = ERR_NONE;
            queue_result(KIND_SUMMARY, '0, '0, e);
            clear_parser();
        end
        else
        begin
            case (pr_phase)
                PH_FRESH, PH_BLANKS:
                    if (c == CH_NL)
                    begin
                        count_line();
                        pr_phase = PH_FRESH;
                    end
                    else if (blank) pr_phase = PH_BLANKS;
                    else if (c == CH_COLON)
                    begin
                        pr_phase = PH_TOKEN;
                        pr_tok   = 1;
                        pr_nib   = '0;
                        pr_count = '0;
                        pr_addr  = '0;
                        pr_type  = '0;
                        pr_sum   = '0;
                        pr_check = '0;
                    end
                    else pr_phase = PH_SKIP;
                PH_SKIP:
                    if (c == CH_NL)
                    begin
                        count_line();
                        pr_phase = PH_FRESH;
                    end
                PH_TAIL:
                    if (c == CH_NL)
                    begin
                        count_line();
                        close_record(1'b0);
                    end
                PH_TOKEN:
                    if (c == CH_NL)
                    begin
                        count_line();
                        close_record(1'b0);
                    end
                    else if (blank) pr_phase = PH_TAIL;
                    else absorb_char(c);
                default: ;
            endcase
        end
        if (pending_q.size() > depth_at_entry) pending_q[pending_q.size() - 1].last = 1'b1;
    endtask

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // one request on the slave side; entered and left just after a rising edge
    task automatic send_char(input logic [7:0] c, input bit eos);
        int gap;
        gap = tx_calm ? 0 : pick_gap();
        @(negedge clk);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= c;
        s_tlast  <= eos;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        predict_request(c, eos);
        chars_sent++;
    endtask

    task automatic send_text(input string txt);
        for (int i = 0; i < txt.len(); i++) send_char(txt[i], 1'b0);
    endtask

    // hex digit text of one byte, upper or lower case at random
    task automatic send_hex(input logic [7:0] b);
        logic [7:0] ch;
        for (int h = 1; h >= 0; h--)
        begin
            ch = (h == 1) ? b[7:4] : b[3:0];
            if (ch < 10) ch = ch + "0";
            else ch = ch - 10 + (($urandom_range(0, 3) == 0) ? "a" : "A");
            send_char(ch, 1'b0);
        end
    endtask

    // one record line, well formed unless spoilt
    task automatic send_record(input logic [7:0] n, input logic [15:0] a,
                               input logic [7:0] t, input logic [15:0] word,
                               input bit spoil);
        logic [7:0] body [$];
        logic [7:0] sum;
        int         cut;
        body = {n, a[15:8], a[7:0], t};
        for (int i = 0; i < n; i++)
            body.push_back((t == REC_DATA) ? 8'($urandom) : ((i == 0) ? word[15:8] : word[7:0]));
        sum = '0;
        foreach (body[i]) sum = sum + body[i];
        body.push_back(8'(-sum));
        cut = body.size();
        if (spoil)
        begin
            case ($urandom_range(0, 2))
                0: body[body.size() - 1] = body[body.size() - 1] ^ 8'($urandom_range(1, 255));
                1: cut = $urandom_range(0, body.size() - 1);
                default: body[$urandom_range(0, body.size() - 1)] = 8'($urandom);
            endcase
        end
        if ($urandom_range(0, 4) == 0) send_char(($urandom_range(0, 1)) ? CH_TAB : CH_SPACE, 1'b0);
        send_char(CH_COLON, 1'b0);
        for (int i = 0; i < cut; i++) send_hex(body[i]);
        if ($urandom_range(0, 9) == 0) send_char(8'h0D, 1'b0);
        if ($urandom_range(0, 5) == 0) send_text(" ; note");
    endtask

    // a stream of records and noise, closed by the end-of-stream request
    task automatic send_stream();
        int         lines;
        int         r;
        logic [7:0] n;
        lines = $urandom_range(1, 5);
        tx_calm = ($urandom_range(0, 3) == 0);
        rx_calm = ($urandom_range(0, 3) == 0);
        for (int l = 0; l < lines; l++)
        begin
            r = $urandom_range(0, 99);
            if (r < 55)
            begin
                n = ($urandom_range(0, 7) == 0) ? 8'd32 : 8'($urandom_range(0, 6));
                send_record(n, 16'($urandom), REC_DATA, '0, $urandom_range(0, 9) == 0);
            end
            else if (r < 65)
                send_record(8'd2, '0, REC_SEG, 16'($urandom_range(0, 'h1001)),
                            $urandom_range(0, 9) == 0);
            else if (r < 75)
                send_record(8'd2, '0, REC_LINEAR, 16'($urandom_range(0, 'h100)),
                            $urandom_range(0, 9) == 0);
            else if (r < 80) send_record('0, '0, REC_EOF, '0, 1'b0);
            else if (r < 90)
            begin
                // junk line: '#', then random characters from 11 to 255, never a line end
                send_char("#", 1'b0);
                repeat ($urandom_range(1, 6)) send_char(8'($urandom_range(11, 255)), 1'b0);
            end
            else
                send_record(8'($urandom_range(0, 40)), 16'($urandom), 8'($urandom_range(0, 7)),
                            16'($urandom), $urandom_range(0, 1));
            if (l < lines - 1 || $urandom_range(0, 6) != 0) send_char(CH_NL, 1'b0);
        end
        send_char(8'($urandom), 1'b1);
    endtask

    // receiver: stalls of random length, sometimes none for a while
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            rx_hold  = 0;
        end
        else if (rx_hold > 0)
        begin
            m_tready <= 1'b0;
            rx_hold--;
        end
        else
        begin
            m_tready <= 1'b1;
            if (!rx_calm) rx_hold = pick_gap();
        end
    end

    // result check and watchdog
    always @(posedge clk)
    begin
        loader_result_t got;
        loader_result_t want;
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles = 0;
            else idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("watchdog: no request moved for %0d cycles", idle_cycles);
                $display("Test completed with failures");
                $finish;
            end
            if (m_tvalid && m_tready)
            begin
                got.kind = result_kind_t'(m_tuser);
                got.addr = m_tdata[23:0];
                got.data = m_tdata[31:24];
                got.code = err_code_t'(m_tdata[35:32]);
                got.line = m_tdata[55:36];
                got.low  = m_tdata[80:56];
                got.high = m_tdata[105:81];
                got.last = m_tlast;
                case (got.kind)
                    KIND_WRITE: writes_seen++;
                    KIND_ERROR: errors_seen++;
                    default:    summaries_seen++;
                endcase
                if (pending_q.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10) $display("unexpected result %p", got);
                end
                else
                begin
                    want = pending_q.pop_front();
                    if (got !== want)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("result mismatch\n  expected %p\n  actual   %p", want, got);
                    end
                end
            end
        end
    end

    // directed lines; an empty row is the end-of-stream request, and the code is
    // the one the last result of the row must carry (-1: not typed in)
    string dir_text [] = '{
        ":0400000001020304F2\n", ":020000021000EC\n", ":0100000011EE\n",
        ":020000040001F9\n", " \tjunk line\n", ":00000001FF\n", "",
        ":0000000\n", "", ":2100000000\n", "", ":0200000000\n", "",
        ":01000000AB00\n", "", ":00000101FE\n", "", ":0100000200FD\n", "",
        ":020000021001EB\n", "", ":0100000400FB\n", "", ":020000040100F9\n", "",
        ":00000003FD\n", "", ":0200000400FFFB\n", ":02FFFF00AABB9B\n", "",
        ":00000001FF", "", ""
    };
    int dir_code [] = '{
        -1, -1, -1, -1, -1, -1, ERR_NONE,
        ERR_SHORT, ERR_SHORT, ERR_TOO_LONG, ERR_TOO_LONG, ERR_MISSING, ERR_MISSING,
        ERR_CHECKSUM, ERR_CHECKSUM, ERR_EOF_REC, ERR_EOF_REC, ERR_SEG_FORM, ERR_SEG_FORM,
        ERR_SEG_VALUE, ERR_SEG_VALUE, ERR_LIN_FORM, ERR_LIN_FORM, ERR_LIN_VALUE, ERR_LIN_VALUE,
        ERR_BAD_TYPE, ERR_BAD_TYPE, -1, -1, ERR_OVERFLOW,
        -1, ERR_NO_DATA, ERR_NO_DATA
    };

    initial
    begin
        bit drained_once;
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tlast = 1'b0;
        m_tready = 1'b0;
        mismatches = 0;
        chars_sent = 0;
        writes_seen = 0;
        errors_seen = 0;
        summaries_seen = 0;
        idle_cycles = 0;
        tx_calm = 1'b0;
        rx_calm = 1'b0;
        drained_once = 1'b0;
        clear_parser();
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(posedge clk);

        for (int row = 0; row < dir_text.size(); row++)
        begin
            if (dir_text[row].len() == 0) send_char(8'($urandom), 1'b1);
            else send_text(dir_text[row]);
            if (dir_code[row] >= 0 && last_code != dir_code[row])
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("directed row %0d: code %0d predicted, %0d typed in",
                             row, last_code, dir_code[row]);
            end
        end

        while (chars_sent < ITEM_TARGET)
        begin
            send_stream();
            // hold the sender once until the master side has drained
            if (!drained_once)
            begin
                drained_once = 1'b1;
                @(negedge clk);
                s_tvalid <= 1'b0;
                while (pending_q.size() != 0) @(posedge clk);
            end
        end
        @(negedge clk);
        s_tvalid <= 1'b0;

        while (pending_q.size() != 0) @(posedge clk);
        repeat (100) @(posedge clk);
        $display("%0d characters sent; %0d byte writes, %0d error reports, %0d summaries checked",
                 chars_sent, writes_seen, errors_seen, summaries_seen);
        $display("%0d mismatches", mismatches);
        if (mismatches == 0 && pending_q.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

[files.f]
sv/ihex_pkg.sv
sv/ihex_cmd_queue.sv
sv/ihex_front.sv
sv/ihex_back.sv
sv/intel_hex_image_loader_top.sv
test/intel_hex_image_loader_top_tb.sv
